[design/pugm_pkg.sv]
// Shared types, constants and helpers for the phase unwrap group merge block.
// Used by the controller, the datapath, the top level and the port checker.
package pugm_pkg;

  localparam int NUM_VOXELS = 4096;
  localparam int PHASE_BITS = 16;
  localparam int IDX_W      = $clog2(NUM_VOXELS);
  localparam int LINK_W     = IDX_W + 1;
  localparam int CNT_W      = 13;
  localparam int WRAP_W     = 14;
  localparam int WRAP_LIMIT = 4096;
  localparam int PI_FIX     = 1 << (PHASE_BITS - 2);

  localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(NUM_VOXELS);

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_EDGE  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                        kind;
    logic [11:0]                  voxel_a;
    logic [11:0]                  voxel_b;
    logic signed [PHASE_BITS-1:0] phase;
  } in_item_t;

  typedef struct packed {
    logic signed [WRAP_W-1:0] wrap_count;
    logic [11:0]              group_head;
    logic [CNT_W-1:0]         group_size;
    logic                     merged;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EDGE_RD,
    ST_EDGE_HD,
    ST_EDGE_JN,
    ST_WALK_RD,
    ST_WALK_WR,
    ST_REP_RD,
    ST_REP_CNT,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_EDGE,
    RD_HEADS,
    RD_WALK,
    RD_REP,
    RD_REPCNT
  } rd_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_LOAD,
    WR_JOIN,
    WR_WALK
  } wr_op_t;

  typedef struct packed {
    logic   latch;
    rd_op_t rd;
    wr_op_t wr;
    logic   emit;
  } cmd_t;

  typedef struct packed {
    logic same_head;
    logic join_group;
    logic walk_last;
  } status_t;

  function automatic logic signed [WRAP_W-1:0] sat_wrap(input logic signed [WRAP_W:0] v);
    if (v > (WRAP_W+1)'(WRAP_LIMIT)) begin
      return WRAP_W'(WRAP_LIMIT);
    end else if (v < -(WRAP_W+1)'(WRAP_LIMIT)) begin
      return -WRAP_W'(WRAP_LIMIT);
    end
    return v[WRAP_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W:0] v);
    if (v > (CNT_W+1)'(NUM_VOXELS)) begin
      return CNT_W'(NUM_VOXELS);
    end
    return v[CNT_W-1:0];
  endfunction

  // Offset of a moving voxel against a reference voxel.
  function automatic logic signed [1:0] phase_off(input logic signed [PHASE_BITS-1:0] pm,
                                                  input logic signed [PHASE_BITS-1:0] pr);
    logic signed [PHASE_BITS:0] d;
    d = (PHASE_BITS+1)'(pr) - (PHASE_BITS+1)'(pm);
    if (d > (PHASE_BITS+1)'(PI_FIX)) begin
      return 2'sd1;
    end else if (d < -(PHASE_BITS+1)'(PI_FIX)) begin
      return -2'sd1;
    end
    return 2'sd0;
  endfunction

endpackage

[design/pugm_ctrl.sv]
// Sequencing state machine for the group merge block.
// Depends on pugm_pkg; drives the datapath by command and reads its status.
module pugm_ctrl import pugm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  kind_t   start_kind,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (start_kind)
            KIND_LOAD:  state_nxt = ST_LOAD;
            KIND_EDGE:  state_nxt = ST_EDGE_RD;
            KIND_QUERY: state_nxt = ST_REP_RD;
            default:    state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_LOAD:    state_nxt = ST_REP_RD;
      ST_EDGE_RD: state_nxt = ST_EDGE_HD;
      ST_EDGE_HD: state_nxt = status.same_head ? ST_REP_RD : ST_EDGE_JN;
      ST_EDGE_JN: state_nxt = status.join_group ? ST_WALK_RD : ST_REP_RD;
      ST_WALK_RD: state_nxt = ST_WALK_WR;
      ST_WALK_WR: state_nxt = status.walk_last ? ST_REP_RD : ST_WALK_RD;
      ST_REP_RD:  state_nxt = ST_REP_CNT;
      ST_REP_CNT: state_nxt = ST_EMIT;
      ST_EMIT:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '{latch: 1'b0, rd: RD_NONE, wr: WR_NONE, emit: 1'b0};
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      ST_LOAD:    cmd.wr = WR_LOAD;
      ST_EDGE_RD: cmd.rd = RD_EDGE;
      ST_EDGE_HD: cmd.rd = status.same_head ? RD_NONE : RD_HEADS;
      ST_EDGE_JN: cmd.wr = WR_JOIN;
      ST_WALK_RD: cmd.rd = RD_WALK;
      ST_WALK_WR: cmd.wr = WR_WALK;
      ST_REP_RD:  cmd.rd = RD_REP;
      ST_REP_CNT: cmd.rd = RD_REPCNT;
      ST_EMIT:    cmd.emit = 1'b1;
      default:    busy = 1'b1;
    endcase
  end

endmodule

[design/pugm_datapath.sv]
// Voxel tables, merge arithmetic and result register of the group merge block.
// Depends on pugm_pkg; acts only on commands from pugm_ctrl.
module pugm_datapath import pugm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output status_t   status,
  output logic      out_valid,
  output out_item_t out_item
);

  logic signed [PHASE_BITS-1:0] phase_mem [NUM_VOXELS];
  logic [IDX_W-1:0]             head_mem  [NUM_VOXELS];
  logic [LINK_W-1:0]            next_mem  [NUM_VOXELS];
  logic [IDX_W-1:0]             tail_mem  [NUM_VOXELS];
  logic [CNT_W-1:0]             cnt_mem   [NUM_VOXELS];
  logic signed [WRAP_W-1:0]     wrap_mem  [NUM_VOXELS];

  in_item_t                     item_r;
  logic signed [PHASE_BITS-1:0] phase_q0_r, phase_q1_r;
  logic [IDX_W-1:0]             head_q0_r, head_q1_r, tail_q0_r, tail_q1_r;
  logic [LINK_W-1:0]            next_q0_r, next_q1_r;
  logic [CNT_W-1:0]             cnt_q0_r, cnt_q1_r;
  logic signed [WRAP_W-1:0]     wrap_q0_r, wrap_q1_r;

  logic [IDX_W-1:0]             hr_r;
  logic signed [WRAP_W:0]       delta_r;
  logic [LINK_W-1:0]            cur_r;
  logic [LINK_W-1:0]            steps_r;
  logic                         merged_r;
  out_item_t                    out_r;
  logic                         out_valid_r;

  logic [IDX_W-1:0] va, vb;
  assign va = item_r.voxel_a[IDX_W-1:0];
  assign vb = item_r.voxel_b[IDX_W-1:0];

  // Join decision
  logic                     lone_a, lone_b, lone, grow_a;
  logic [IDX_W-1:0]         l_h, l_th, l_v, hm, hr, thr, thm;
  logic [CNT_W-1:0]         l_c, cm, cr;
  logic signed [WRAP_W-1:0] l_w, wm, wr;
  logic signed [1:0]        l_off, g_off;
  logic signed [WRAP_W:0]   delta;

  always_comb begin
    lone_b = (next_q1_r == EMPTY_LINK) && (head_q1_r == vb);
    lone_a = (next_q0_r == EMPTY_LINK) && (head_q0_r == va);
    lone   = lone_a || lone_b;
    grow_a = cnt_q0_r > cnt_q1_r;
    if (lone_b) begin
      l_h   = head_q0_r;
      l_th  = tail_q0_r;
      l_c   = cnt_q0_r;
      l_v   = vb;
      l_w   = wrap_q0_r;
      l_off = phase_off(phase_q1_r, phase_q0_r);
    end else begin
      l_h   = head_q1_r;
      l_th  = tail_q1_r;
      l_c   = cnt_q1_r;
      l_v   = va;
      l_w   = wrap_q1_r;
      l_off = phase_off(phase_q0_r, phase_q1_r);
    end
    if (grow_a) begin
      hm    = head_q1_r;  hr  = head_q0_r;
      thm   = tail_q1_r;  thr = tail_q0_r;
      cm    = cnt_q1_r;   cr  = cnt_q0_r;
      wm    = wrap_q1_r;  wr  = wrap_q0_r;
      g_off = phase_off(phase_q1_r, phase_q0_r);
    end else begin
      hm    = head_q0_r;  hr  = head_q1_r;
      thm   = tail_q0_r;  thr = tail_q1_r;
      cm    = cnt_q0_r;   cr  = cnt_q1_r;
      wm    = wrap_q0_r;  wr  = wrap_q1_r;
      g_off = phase_off(phase_q0_r, phase_q1_r);
    end
    delta = (WRAP_W+1)'(wr) + (WRAP_W+1)'(g_off) - (WRAP_W+1)'(wm);
  end

  logic walk_end;
  assign walk_end = next_q0_r[LINK_W-1] || (steps_r == LINK_W'(NUM_VOXELS - 1));

  assign status = '{same_head: head_q0_r == head_q1_r, join_group: !lone,
                    walk_last: walk_end};

  // Write port selects
  logic                     ph_we, hd_we, nx_we, tl_we, ct_we, wp_we;
  logic [IDX_W-1:0]         hd_wa, nx_wa, tl_wa, ct_wa, wp_wa, tl_wd;
  logic [IDX_W-1:0]         hd_wd;
  logic [LINK_W-1:0]        nx_wd;
  logic [CNT_W-1:0]         ct_wd;
  logic signed [WRAP_W-1:0] wp_wd;

  always_comb begin
    ph_we = 1'b0; hd_we = 1'b0; nx_we = 1'b0; tl_we = 1'b0; ct_we = 1'b0; wp_we = 1'b0;
    hd_wa = va;   hd_wd = va;
    nx_wa = va;   nx_wd = EMPTY_LINK;
    tl_wa = va;   tl_wd = va;
    ct_wa = va;   ct_wd = CNT_W'(1);
    wp_wa = va;   wp_wd = '0;
    case (cmd.wr)
      WR_LOAD: begin
        ph_we = 1'b1; hd_we = 1'b1; nx_we = 1'b1; tl_we = 1'b1; ct_we = 1'b1; wp_we = 1'b1;
      end
      WR_JOIN: begin
        nx_we = 1'b1; tl_we = 1'b1; ct_we = 1'b1;
        if (lone) begin
          hd_we = 1'b1; wp_we = 1'b1;
          nx_wa = l_th; nx_wd = LINK_W'(l_v);
          tl_wa = l_h;  tl_wd = l_v;
          ct_wa = l_h;  ct_wd = sat_cnt((CNT_W+1)'(l_c) + (CNT_W+1)'(1));
          hd_wa = l_v;  hd_wd = l_h;
          wp_wa = l_v;  wp_wd = sat_wrap((WRAP_W+1)'(l_w) + (WRAP_W+1)'(l_off));
        end else begin
          nx_wa = thr;  nx_wd = LINK_W'(hm);
          tl_wa = hr;   tl_wd = thm;
          ct_wa = hr;   ct_wd = sat_cnt((CNT_W+1)'(cr) + (CNT_W+1)'(cm));
        end
      end
      WR_WALK: begin
        hd_we = 1'b1; wp_we = 1'b1;
        hd_wa = cur_r[IDX_W-1:0]; hd_wd = hr_r;
        wp_wa = cur_r[IDX_W-1:0];
        wp_wd = sat_wrap((WRAP_W+1)'(wrap_q0_r) + delta_r);
      end
      default: ph_we = 1'b0;
    endcase
  end

  // Read port selects
  logic             rd_edge, rd_heads, rd_walk, rd_rep, rd_repcnt;
  logic [IDX_W-1:0] p0_a, c0_a;
  assign rd_edge   = cmd.rd == RD_EDGE;
  assign rd_heads  = cmd.rd == RD_HEADS;
  assign rd_walk   = cmd.rd == RD_WALK;
  assign rd_rep    = cmd.rd == RD_REP;
  assign rd_repcnt = cmd.rd == RD_REPCNT;
  assign p0_a      = rd_walk ? cur_r[IDX_W-1:0] : va;
  assign c0_a      = head_q0_r;

  always_ff @(posedge clk) begin
    if (ph_we) phase_mem[va] <= item_r.phase;
    if (rd_edge) begin
      phase_q0_r <= phase_mem[va];
      phase_q1_r <= phase_mem[vb];
    end
  end

  always_ff @(posedge clk) begin
    if (hd_we) head_mem[hd_wa] <= hd_wd;
    if (rd_edge || rd_rep) head_q0_r <= head_mem[va];
    if (rd_edge) head_q1_r <= head_mem[vb];
  end

  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (rd_edge || rd_walk) next_q0_r <= next_mem[p0_a];
    if (rd_edge) next_q1_r <= next_mem[vb];
  end

  always_ff @(posedge clk) begin
    if (tl_we) tail_mem[tl_wa] <= tl_wd;
    if (rd_heads) begin
      tail_q0_r <= tail_mem[head_q0_r];
      tail_q1_r <= tail_mem[head_q1_r];
    end
  end

  always_ff @(posedge clk) begin
    if (ct_we) cnt_mem[ct_wa] <= ct_wd;
    if (rd_heads || rd_repcnt) cnt_q0_r <= cnt_mem[c0_a];
    if (rd_heads) cnt_q1_r <= cnt_mem[head_q1_r];
  end

  always_ff @(posedge clk) begin
    if (wp_we) wrap_mem[wp_wa] <= wp_wd;
    if (rd_edge || rd_walk || rd_rep) wrap_q0_r <= wrap_mem[p0_a];
    if (rd_edge) wrap_q1_r <= wrap_mem[vb];
  end

  // Input capture, walk registers, result
  always_ff @(posedge clk) begin
    if (cmd.latch) item_r <= in_item;
    if (cmd.wr == WR_JOIN) begin
      hr_r    <= hr;
      delta_r <= delta;
      cur_r   <= LINK_W'(hm);
      steps_r <= '0;
    end else if (cmd.wr == WR_WALK) begin
      cur_r   <= next_q0_r;
      steps_r <= steps_r + LINK_W'(1);
    end
    if (cmd.emit) begin
      if (item_r.kind == KIND_NONE) begin
        out_r <= '0;
      end else begin
        out_r <= '{wrap_count: wrap_q0_r, group_head: 12'(head_q0_r),
                   group_size: cnt_q0_r, merged: merged_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      merged_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.latch) begin
        merged_r <= 1'b0;
      end else if (cmd.wr == WR_JOIN) begin
        merged_r <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

[design/phase_unwrap_group_merge.sv]
// Top level of the phase unwrap group merge block.
// Depends on pugm_pkg, pugm_ctrl and pugm_datapath.
//
// Groups voxels for 3D phase unwrapping, one transaction at a time. A
// transaction is taken when start is high and busy is low; its single result
// appears on out_item for exactly one cycle with out_valid high, and the
// receiver cannot stall it. A query reads the voxel's head and wrap, then its
// group's count; a load first writes the voxel as a lone group, then does the
// same reads; an unused kind goes straight to the result. An edge reads both
// voxels and, unless they share a group, the tail and count of both groups,
// then appends a lone voxel or merges the groups, relabelling each member of
// the moving group (at most NUM_VOXELS) by a read and a write, and ends with
// the query reads. busy drops in the strobe cycle, so the next transaction
// may be taken there. The voxel tables are not cleared after reset; every
// voxel must be loaded before an edge or query uses it.
module phase_unwrap_group_merge import pugm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_item,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_item
);

  cmd_t    cmd;
  status_t status;

  // Sequencer: owns start/busy, issues table reads and writes.
  pugm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .start_kind (in_item.kind),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  // Tables, join arithmetic and result register.
  pugm_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

[design/pugm_checker.sv]
// Port-level checks for phase_unwrap_group_merge, bound to the top level.
// Depends on pugm_pkg for the payload types.
module pugm_checker import pugm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // An accepted transaction makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after accept");

  // Result strobe lasts one cycle
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  // A result arrives only once the block has gone idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  // No result in the cycle after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid) else $error("result too early");

  // Group size of a reported group is never zero when a merge happened
  a_merge_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.merged |-> out_item.group_size != '0)
    else $error("merged result with empty group");

endmodule

bind phase_unwrap_group_merge pugm_checker u_pugm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
